/* design/ttbl_pkg.sv */
// Package for the thrust-to-throttle lookup: table sizes, widths, request codes
// and reset values.
// It has no dependencies.
`timescale 1ns / 1ps

package ttbl_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int MAX_POINTS = 32;
    localparam int LVL_W      = 3;
    localparam int PT_W       = 5;
    localparam int ADDR_W     = LVL_W + PT_W;
    localparam int CNT_W      = 6;
    localparam int NLEV_W     = 4;
    localparam int RAM_W      = 32;

    localparam logic [15:0] NEUTRAL_RST = 16'd24000;
    localparam logic [15:0] BATT_RST    = 16'd12000;

    typedef logic [1:0] req_t;
    localparam req_t REQ_LOAD    = 2'd0;
    localparam req_t REQ_VOLTAGE = 2'd1;
    localparam req_t REQ_QUERY   = 2'd2;

endpackage

/* design/ttbl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
`timescale 1ns / 1ps

module ttbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/thrust_to_throttle_bilinear_lookup.sv */
// Top level of the thrust-to-throttle lookup with two-dimensional interpolation.
// It depends on ttbl_pkg and ttbl_ram.
//
// Usage:
// The input stream (s_*) carries load words, which write one curve point;
// voltage words, which set the battery voltage; and query words. Each query
// returns one output word (m_*) with the interpolated throttle and a flag
// that tells whether the neutral throttle was used for missing data.
// The neutral throttle is set through cfg_we and cfg_wdata.
// Load and voltage words are taken in the idle state. A query on an empty
// table goes straight to the output state. Any other query scans the level
// voltages, then the points of one level or of two levels, and does at most
// 3 divisions: one per level for the thrust and one for the voltage blend.
// Each division has a multiply step, 32 quotient bits at one per cycle on a
// shared restoring divider, and an add step. The point RAM is read one point
// per cycle.
// Reset empties the table, sets the battery voltage to 12000 mV and the
// neutral throttle to 24000. It needs no clearing pass.
// When the receiver stalls, the result stays in the output register. The
// next word is still accepted. A later query waits until the output
// register has been emptied.
`timescale 1ns / 1ps

module thrust_to_throttle_bilinear_lookup
    import ttbl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] level_index, [7:3] point_index, [23:8] voltage_mv,
    // [39:24] thrust_cn, [55:40] throttle_q
    input  logic [55:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] throttle_out
    output logic [15:0] m_tdata,
    // [0] used_default
    output logic [0:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LSCAN, ST_LSTART, ST_PSCAN, ST_PEVAL,
        ST_LDONE, ST_MUL, ST_DIV, ST_ADD, ST_OUT
    } state_t;

    state_t state_reg;

    // Table control state.
    logic [15:0]       neutral_reg;
    logic [15:0]       batt_reg;
    logic [NLEV_W-1:0] nlev_reg;
    logic [CNT_W-1:0]  cnt_reg [MAX_LEVELS];
    logic [15:0]       lv_reg  [MAX_LEVELS];

    // Query working registers.
    logic signed [15:0] thrust_reg;
    logic [NLEV_W-1:0]  li_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic               two_reg;
    logic               pass_reg;
    logic               dflt_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   dk_reg;
    logic               dv_reg;
    logic               hit_reg;
    logic signed [15:0] first_t_reg;
    logic [15:0]        first_p_reg;
    logic signed [15:0] prev_t_reg;
    logic [15:0]        prev_p_reg;
    logic signed [15:0] hi_t_reg;
    logic [15:0]        hi_p_reg;
    logic [15:0]        lres_reg;
    logic [15:0]        tha_reg;
    logic [15:0]        res_reg;

    // Shared interpolation unit: y1 + off * (y2 - y1) / span.
    logic [15:0] off_reg;
    logic [15:0] span_reg;
    logic [15:0] y1_reg;
    logic [15:0] y2_reg;
    logic        fin_reg;
    logic        neg_reg;
    logic [31:0] q_reg;
    logic [15:0] rem_reg;
    logic [4:0]  dcnt_reg;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        m_user_reg;

    // Input field views.
    req_t             in_req;
    logic [LVL_W-1:0] in_lvl;
    logic [PT_W-1:0]  in_pt;
    logic [15:0]      in_volt;
    logic [15:0]      in_thrust;
    logic [15:0]      in_thr;
    logic             in_acc;

    assign in_req    = s_tuser;
    assign in_lvl    = s_tdata[2:0];
    assign in_pt     = s_tdata[7:3];
    assign in_volt   = s_tdata[23:8];
    assign in_thrust = s_tdata[39:24];
    assign in_thr    = s_tdata[55:40];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;

    // Point RAM: {thrust, throttle} at {level, point}.
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [RAM_W-1:0]    wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [RAM_W-1:0]    rd_data;
    logic [CNT_W-1:0]    cur_cnt;

    assign wr_en   = in_acc && (in_req == REQ_LOAD);
    assign wr_addr = {in_lvl, in_pt};
    assign wr_data = {in_thrust, in_thr};
    assign cur_cnt = cnt_reg[lvl_reg];
    assign rd_en   = (state_reg == ST_PSCAN) && (k_reg < cur_cnt);
    assign rd_addr = {lvl_reg, k_reg[PT_W-1:0]};

    ttbl_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_LEVELS * MAX_POINTS)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Point scan decisions on the word returned by the RAM.
    logic signed [15:0] cur_t;
    logic [15:0]        cur_p;
    logic               pt_hit;
    logic               pt_done;

    assign cur_t   = $signed(rd_data[31:16]);
    assign cur_p   = rd_data[15:0];
    assign pt_hit  = dv_reg && (dk_reg != '0) && (thrust_reg >= prev_t_reg)
                     && (thrust_reg <= cur_t);
    assign pt_done = dv_reg && (pt_hit || (dk_reg == cur_cnt - 1'b1));

    // Level scan view and differences for the interpolation setup.
    logic [15:0]        lv_at;
    logic [15:0]        lv_lo;
    logic signed [16:0] t_off;
    logic signed [16:0] t_span;
    logic [16:0]        y_diff;
    logic [15:0]        y_mag;
    logic [16:0]        trial;
    logic [15:0]        add_res;

    assign lv_at   = lv_reg[li_reg[LVL_W-1:0]];
    assign lv_lo   = lv_reg[lvl_reg];
    assign t_off   = {thrust_reg[15], thrust_reg} - {prev_t_reg[15], prev_t_reg};
    assign t_span  = {hi_t_reg[15], hi_t_reg} - {prev_t_reg[15], prev_t_reg};
    assign y_diff  = {1'b0, y2_reg} - {1'b0, y1_reg};
    assign y_mag   = y_diff[16] ? 16'(-y_diff) : y_diff[15:0];
    assign trial   = {rem_reg, q_reg[31]};
    assign add_res = neg_reg ? (y1_reg - q_reg[15:0]) : (y1_reg + q_reg[15:0]);

    // Table writes, query sequencer, divider and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            neutral_reg <= NEUTRAL_RST;
            batt_reg    <= BATT_RST;
            nlev_reg    <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                neutral_reg <= cfg_wdata;
            end
            // The output state loads a new word itself, so it handles its own drain.
            if (m_valid_reg && m_tready && state_reg != ST_OUT)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (in_req)
                            REQ_LOAD:
                            begin
                                lv_reg[in_lvl] <= in_volt;
                                if (cnt_reg[in_lvl] < {1'b0, in_pt} + 1'b1)
                                begin
                                    cnt_reg[in_lvl] <= {1'b0, in_pt} + 1'b1;
                                end
                                if (nlev_reg < {1'b0, in_lvl} + 1'b1)
                                begin
                                    nlev_reg <= {1'b0, in_lvl} + 1'b1;
                                end
                            end
                            REQ_VOLTAGE:
                            begin
                                batt_reg <= in_volt;
                            end
                            REQ_QUERY:
                            begin
                                thrust_reg <= $signed(in_thrust);
                                li_reg     <= '0;
                                pass_reg   <= 1'b0;
                                if (nlev_reg == '0)
                                begin
                                    res_reg   <= neutral_reg;
                                    dflt_reg  <= 1'b1;
                                    state_reg <= ST_OUT;
                                end
                                else
                                begin
                                    dflt_reg  <= 1'b0;
                                    state_reg <= ST_LSCAN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_LSCAN:
                begin
                    if (li_reg == nlev_reg)
                    begin
                        lvl_reg   <= LVL_W'(nlev_reg - 1'b1);
                        two_reg   <= 1'b0;
                        state_reg <= ST_LSTART;
                    end
                    else if (lv_at >= batt_reg)
                    begin
                        if (li_reg == '0 || lv_at == batt_reg)
                        begin
                            lvl_reg <= li_reg[LVL_W-1:0];
                            two_reg <= 1'b0;
                        end
                        else
                        begin
                            lvl_reg <= LVL_W'(li_reg - 1'b1);
                            two_reg <= 1'b1;
                        end
                        state_reg <= ST_LSTART;
                    end
                    else
                    begin
                        li_reg <= li_reg + 1'b1;
                    end
                end
                ST_LSTART:
                begin
                    k_reg  <= '0;
                    dv_reg <= 1'b0;
                    if (cur_cnt == '0)
                    begin
                        lres_reg  <= neutral_reg;
                        dflt_reg  <= 1'b1;
                        state_reg <= ST_LDONE;
                    end
                    else
                    begin
                        state_reg <= ST_PSCAN;
                    end
                end
                ST_PSCAN:
                begin
                    if (dv_reg && dk_reg == '0)
                    begin
                        first_t_reg <= cur_t;
                        first_p_reg <= cur_p;
                    end
                    if (pt_done)
                    begin
                        hit_reg   <= pt_hit;
                        hi_t_reg  <= cur_t;
                        hi_p_reg  <= cur_p;
                        dv_reg    <= 1'b0;
                        state_reg <= ST_PEVAL;
                    end
                    else
                    begin
                        if (dv_reg)
                        begin
                            prev_t_reg <= cur_t;
                            prev_p_reg <= cur_p;
                        end
                        dv_reg <= rd_en;
                        dk_reg <= k_reg;
                        if (rd_en)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_PEVAL:
                begin
                    if (hit_reg)
                    begin
                        if (hi_t_reg == prev_t_reg)
                        begin
                            lres_reg  <= prev_p_reg;
                            state_reg <= ST_LDONE;
                        end
                        else
                        begin
                            off_reg   <= t_off[15:0];
                            span_reg  <= t_span[15:0];
                            y1_reg    <= prev_p_reg;
                            y2_reg    <= hi_p_reg;
                            fin_reg   <= 1'b0;
                            state_reg <= ST_MUL;
                        end
                    end
                    else
                    begin
                        lres_reg  <= (thrust_reg < first_t_reg) ? first_p_reg : hi_p_reg;
                        state_reg <= ST_LDONE;
                    end
                end
                ST_LDONE:
                begin
                    if (!pass_reg)
                    begin
                        tha_reg <= lres_reg;
                        if (two_reg)
                        begin
                            pass_reg  <= 1'b1;
                            lvl_reg   <= lvl_reg + 1'b1;
                            state_reg <= ST_LSTART;
                        end
                        else
                        begin
                            res_reg   <= lres_reg;
                            state_reg <= ST_OUT;
                        end
                    end
                    else
                    begin
                        // Voltage interpolation between the lower and upper level.
                        off_reg   <= batt_reg - lv_reg[lvl_reg - 1'b1];
                        span_reg  <= lv_lo - lv_reg[lvl_reg - 1'b1];
                        y1_reg    <= tha_reg;
                        y2_reg    <= lres_reg;
                        fin_reg   <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    q_reg     <= off_reg * y_mag;
                    neg_reg   <= y_diff[16];
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // One restoring quotient bit per cycle.
                    if (trial >= {1'b0, span_reg})
                    begin
                        rem_reg <= 16'(trial - {1'b0, span_reg});
                        q_reg   <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[15:0];
                        q_reg   <= {q_reg[30:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 5'd31)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    if (fin_reg)
                    begin
                        res_reg   <= add_res;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        lres_reg  <= add_res;
                        state_reg <= ST_LDONE;
                    end
                end
                ST_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        m_user_reg  <= dflt_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    // A query on a loaded table keeps the input closed on the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_req == REQ_QUERY && nlev_reg != '0) |=> !s_tready)
        else $error("query did not close the input");

    // The point scan never reads past the level's point count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (k_reg < cur_cnt) && (cur_cnt != '0))
        else $error("point read beyond level count");

    // The divider remainder stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder out of range");
`endif

endmodule

/* dv/thrust_to_throttle_bilinear_lookup_test.sv */
// Testbench for the thrust-to-throttle lookup: drives load, voltage and query words,
// predicts each query result with its own model of the curve table and checks it.
// It depends on ttbl_pkg and the thrust_to_throttle_bilinear_lookup design.
`timescale 1ns / 1ps

module thrust_to_throttle_bilinear_lookup_test;
    import ttbl_pkg::*;

    typedef struct packed {
        logic [15:0] throttle;
        logic        dflt;
    } lookup_result_t;

    // Request code that the block must ignore.
    localparam req_t REQ_UNKNOWN = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // Shadow copy of the curve table and settings.
    logic [15:0] mdl_neutral;
    logic [15:0] mdl_lvl_mv [MAX_LEVELS];
    logic [15:0] mdl_pt_thrust [MAX_LEVELS][MAX_POINTS];
    logic [15:0] mdl_pt_throttle [MAX_LEVELS][MAX_POINTS];
    int          mdl_pt_count [MAX_LEVELS];
    int          mdl_levels;
    logic [15:0] mdl_batt_mv;

    lookup_result_t expected_throttles[$];
    int  error_count;
    int  idle_cycles;
    int  queries_sent;
    int  results_seen;
    bit  sink_stall_en;

    thrust_to_throttle_bilinear_lookup dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Throttle of one level at a given thrust, clamped to the end points.
    function automatic longint level_throttle(int lvl, longint t, ref bit dflt);
        int     c;
        longint t1;
        longint t2;
        longint p1;
        longint p2;
        c = mdl_pt_count[lvl];
        if (c == 0)
        begin
            dflt = 1'b1;
            return longint'(mdl_neutral);
        end
        for (int i = 0; i + 1 < c; i++)
        begin
            t1 = longint'($signed(mdl_pt_thrust[lvl][i]));
            t2 = longint'($signed(mdl_pt_thrust[lvl][i + 1]));
            if (t >= t1 && t <= t2)
            begin
                p1 = longint'(mdl_pt_throttle[lvl][i]);
                p2 = longint'(mdl_pt_throttle[lvl][i + 1]);
                if (t2 == t1)
                    return p1;
                return p1 + ((t - t1) * (p2 - p1)) / (t2 - t1);
            end
        end
        if (t < longint'($signed(mdl_pt_thrust[lvl][0])))
            return longint'(mdl_pt_throttle[lvl][0]);
        return longint'(mdl_pt_throttle[lvl][c - 1]);
    endfunction

    // Full query: pick the bracketing levels and interpolate over voltage.
    function automatic lookup_result_t predict_throttle(logic [15:0] thrust);
        lookup_result_t r;
        bit     dflt;
        longint res;
        longint v;
        longint t;
        longint v1;
        longint v2;
        longint th1;
        longint th2;
        int     i;
        dflt = 1'b0;
        v = longint'(mdl_batt_mv);
        t = longint'($signed(thrust));
        if (mdl_levels == 0)
        begin
            res = longint'(mdl_neutral);
            dflt = 1'b1;
        end
        else
        begin
            for (i = 0; i < mdl_levels; i++)
                if (longint'(mdl_lvl_mv[i]) >= v)
                    break;
            if (i == mdl_levels)
                res = level_throttle(mdl_levels - 1, t, dflt);
            else if (i == 0 || longint'(mdl_lvl_mv[i]) == v)
                res = level_throttle(i, t, dflt);
            else
            begin
                v1 = longint'(mdl_lvl_mv[i - 1]);
                v2 = longint'(mdl_lvl_mv[i]);
                th1 = level_throttle(i - 1, t, dflt);
                th2 = level_throttle(i, t, dflt);
                res = th1 + ((v - v1) * (th2 - th1)) / (v2 - v1);
            end
        end
        r.throttle = res[15:0];
        r.dflt = dflt;
        return r;
    endfunction

    // Send one word and update the shadow table once it is accepted.
    task automatic send_word(req_t req, logic [2:0] lvl, logic [4:0] pt,
                             logic [15:0] mv, logic [15:0] thrust, logic [15:0] thr);
        int gap;
        gap = $urandom_range(0, 5);
        repeat (gap) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {thr, thrust, mv, pt, lvl};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        case (req)
            REQ_LOAD:
            begin
                mdl_lvl_mv[lvl] = mv;
                mdl_pt_thrust[lvl][pt] = thrust;
                mdl_pt_throttle[lvl][pt] = thr;
                if (mdl_pt_count[lvl] < int'(pt) + 1)
                    mdl_pt_count[lvl] = int'(pt) + 1;
                if (mdl_levels < int'(lvl) + 1)
                    mdl_levels = int'(lvl) + 1;
            end
            REQ_VOLTAGE: mdl_batt_mv = mv;
            REQ_QUERY:
            begin
                expected_throttles.insert(expected_throttles.size(),
                                          predict_throttle(thrust));
                queries_sent++;
            end
            default: ;
        endcase
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Wait until every query has answered, then let the block settle.
    task automatic drain_results();
        while (expected_throttles.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_neutral(logic [15:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mdl_neutral = value;
    endtask

    // Load a well-formed level: ascending distinct thrusts, random throttles.
    task automatic load_level(int lvl, logic [15:0] mv, int npts);
        int t;
        t = -32768 + int'($urandom_range(0, 2000));
        for (int p = 0; p < npts; p++)
        begin
            send_word(REQ_LOAD, lvl[2:0], p[4:0], mv, t[15:0], 16'($urandom));
            t = t + 1 + int'($urandom_range(0, 65535 / (npts + 1)));
            if (t > 32767)
                t = 32767;
        end
    endtask

    task automatic query(logic [15:0] thrust);
        send_word(REQ_QUERY, 3'd0, 5'd0, 16'($urandom), thrust, 16'($urandom));
    endtask

    // Empty table, the unknown request code and the neutral throttle extremes.
    task automatic test_empty_table();
        query(16'h8000);
        send_word(REQ_UNKNOWN, 3'd7, 5'd31, 16'hffff, 16'h7fff, 16'hffff);
        write_neutral(16'h0000);
        query(16'h7fff);
        write_neutral(16'hffff);
        query(16'h0000);
        write_neutral(NEUTRAL_RST);
    endtask

    // Single point, equal thrusts, clamping, voltage below and above the table.
    task automatic test_directed_curve();
        send_word(REQ_LOAD, 3'd0, 5'd0, 16'd11000, 16'd100, 16'd20000);
        query(16'h8000);
        send_word(REQ_LOAD, 3'd0, 5'd1, 16'd11000, 16'd100, 16'd30000);
        send_word(REQ_LOAD, 3'd0, 5'd2, 16'd11000, 16'h7fff, 16'hffff);
        query(16'd100);
        query(16'h7fff);
        query(16'd5000);
        send_word(REQ_LOAD, 3'd2, 5'd0, 16'd16000, 16'h8000, 16'd0);
        send_word(REQ_LOAD, 3'd2, 5'd1, 16'd16000, 16'h7fff, 16'd40000);
        send_word(REQ_LOAD, 3'd1, 5'd0, 16'd13000, 16'h8000, 16'd1000);
        send_word(REQ_LOAD, 3'd1, 5'd1, 16'd13000, 16'h8000, 16'd1000);
        send_word(REQ_VOLTAGE, 3'd0, 5'd0, 16'd0, 16'd0, 16'd0);
        query(16'd200);
        send_word(REQ_VOLTAGE, 3'd0, 5'd0, 16'hffff, 16'd0, 16'd0);
        query(16'hff00);
        send_word(REQ_VOLTAGE, 3'd0, 5'd0, 16'd14500, 16'd0, 16'd0);
        query(16'd1234);
        send_word(REQ_VOLTAGE, 3'd0, 5'd0, 16'd13000, 16'd0, 16'd0);
        query(16'h8000);
    endtask

    // Random tables of sorted levels, then mostly queries with some voltage and unknown words.
    // Every level below the highest one loaded is written, so no query can
    // see a level voltage or a point that was never written.
    task automatic test_random_tables(int rounds);
        int nlev;
        int mv;
        for (int r = 0; r < rounds; r++)
        begin
            drain_results();
            if (r % 4 == 1)
                write_neutral(16'($urandom));
            nlev = $urandom_range(1, MAX_LEVELS);
            mv = $urandom_range(0, 3000);
            for (int l = 0; l < nlev; l++)
            begin
                load_level(l, mv[15:0], (r % 5 == 0) ? $urandom_range(1, 32)
                                                      : $urandom_range(1, 5));
                mv = mv + 1 + $urandom_range(0, 8000);
                if (mv > 65535)
                    mv = 65535;
            end
            for (int q = 0; q < 20; q++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_word(REQ_VOLTAGE, 3'($urandom), 5'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                else if ($urandom_range(0, 15) == 0)
                    send_word(REQ_UNKNOWN, 3'($urandom), 5'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                else
                    query(16'($urandom));
            end
        end
    endtask

    // Results: with stalls enabled, the receive side may drop ready before taking each word.
    initial
    begin
        int wait_cycles;
        m_tready = 1'b0;
        forever
        begin
            wait_cycles = sink_stall_en ? $urandom_range(0, 5) : 0;
            if (wait_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk iff (m_tvalid === 1'b1));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_throttles.size() == 0)
            begin
                $error("unexpected result throttle_out=%0d", m_tdata);
                error_count++;
            end
            else
            begin
                lookup_result_t e;
                e = expected_throttles.pop_front();
                if (m_tdata !== e.throttle)
                begin
                    $error("throttle_out expected %0d actual %0d", e.throttle, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== e.dflt)
                begin
                    $error("used_default expected %0d actual %0d", e.dflt, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_LOAD;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        idle_cycles = 0;
        queries_sent = 0;
        results_seen = 0;
        sink_stall_en = 1'b1;
        mdl_neutral = NEUTRAL_RST;
        mdl_batt_mv = BATT_RST;
        mdl_levels = 0;
        foreach (mdl_pt_count[i]) mdl_pt_count[i] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_directed_curve();
        test_random_tables(20);
        drain_results();

        $display("Covered empty table, neutral extremes, clamping and blends: %0d queries,",
                 queries_sent);
        $display("%0d results checked over random sorted curve tables.", results_seen);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
